[rtl/pfcg_pkg.sv]
`timescale 1ns / 1ps

package pfcg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int FORMAT_W = 2;
   localparam int CHANNELS_W = 2;
   localparam int Q_FRAC_BITS = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_FORMAT = 2'd0,
      CSR_OUT_CHANNELS  = 2'd1,
      CSR_APPLY_VOLUME  = 2'd2,
      CSR_VOLUME_GAIN   = 2'd3
   } csr_index_type;

   localparam logic [FORMAT_W-1:0]   SOURCE_FORMAT_RESET = 2'd2;
   localparam logic [CHANNELS_W-1:0] OUT_CHANNELS_RESET  = 2'd2;
   localparam logic                  APPLY_VOLUME_RESET  = 1'b1;
   localparam logic [SAMPLE_W-1:0]   VOLUME_GAIN_RESET   = 16'd4096;

   localparam logic [CHANNELS_W-1:0] CHANNELS_MONO = 2'd1;

   localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Unsigned 8-bit v maps to (v - 128) * 256: flip the top bit, move to the high byte.
   function automatic sample_type to_s16(input sample_type raw, input logic wide);
      sample_type res;
      if (wide) begin
         res = raw;
      end else begin
         res = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
      end
      return res;
   endfunction

endpackage

[rtl/pfcg_req_if.sv]
`timescale 1ns / 1ps

interface pfcg_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfcg_pkg::SAMPLE_W-1:0] first_sample;
   logic [pfcg_pkg::SAMPLE_W-1:0] second_sample;
   logic                        last_frame;

   modport source (output valid, output first_sample, output second_sample,
                   output last_frame, input ready);
   modport sink (input valid, input first_sample, input second_sample,
                 input last_frame, output ready);
endinterface

[rtl/pfcg_rsp_if.sv]
`timescale 1ns / 1ps

interface pfcg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pfcg_pkg::SAMPLE_W-1:0] out_left;
   logic signed [pfcg_pkg::SAMPLE_W-1:0] out_right;
   logic                               out_last;

   modport source (output valid, output out_left, output out_right,
                   output out_last, input ready);
   modport sink (input valid, input out_left, input out_right,
                 input out_last, output ready);
endinterface

[rtl/pfcg_gain.sv]
`timescale 1ns / 1ps

module pfcg_gain (
   input  logic signed [pfcg_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [pfcg_pkg::SAMPLE_W-1:0] gain,
   output logic signed [pfcg_pkg::SAMPLE_W-1:0] scaled
);

   localparam int PROD_W = 2 * pfcg_pkg::SAMPLE_W;
   localparam int QUOT_W = PROD_W - pfcg_pkg::Q_FRAC_BITS;

   logic signed [PROD_W-1:0] product;
   logic signed [PROD_W-1:0] bias;
   logic signed [PROD_W-1:0] product_adj;
   logic signed [QUOT_W-1:0] quotient;
   logic                     fits;

   always_comb begin
      product = sample * gain;
      // bias negative products so the shift truncates toward zero
      bias = product[PROD_W-1]
           ? $signed({{(PROD_W-pfcg_pkg::Q_FRAC_BITS){1'b0}},
                      {pfcg_pkg::Q_FRAC_BITS{1'b1}}})
           : '0;
      product_adj = product + bias;
      quotient = product_adj[PROD_W-1:pfcg_pkg::Q_FRAC_BITS];
      fits = (quotient[QUOT_W-1:pfcg_pkg::SAMPLE_W-1] == '0) ||
             (quotient[QUOT_W-1:pfcg_pkg::SAMPLE_W-1] == '1);
      if (fits) begin
         scaled = quotient[pfcg_pkg::SAMPLE_W-1:0];
      end else if (quotient[QUOT_W-1]) begin
         scaled = pfcg_pkg::S16_MIN;
      end else begin
         scaled = pfcg_pkg::S16_MAX;
      end
   end

endmodule

[rtl/pcm_frame_converter_with_gain_core.sv]
`timescale 1ns / 1ps

// PCM frame converter with gain. Each req beat carries one source frame (one or
// two samples, unsigned 8-bit in the low byte or signed 16-bit); each rsp beat
// carries one signed 16-bit frame in one or two channels, plus the last-frame
// mark. 8-bit samples become (v-128)*256, mono sources are duplicated, stereo
// is averaged to mono (truncated toward zero), and with apply_volume set the
// Q4.12 gain is applied, truncated toward zero and saturated. The block is a
// two-register pipeline: an input register, then conversion, mix and the two
// 16x16 gain multipliers in one combinational pass into the result register.
// It takes one frame per clock while rsp is ready. A frame's rsp beat follows
// its req beat through the input and result registers. When rsp stalls with both
// registers full, req.ready drops in the same cycle, and it rises again in the
// cycle rsp.ready returns. Write the csr registers only while no frame is in
// flight; in mono output out_right is 0.
module pcm_frame_converter_with_gain_core (
   input  logic                                    clock,
   input  logic                                    reset,
   pfcg_req_if.sink                                req,
   pfcg_rsp_if.source                              rsp,
   input  logic                                    csr_wr_en,
   input  logic [pfcg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pfcg_pkg::CSR_DATA_W-1:0]         csr_wr_data
);

   localparam int SW = pfcg_pkg::SAMPLE_W;

   // configuration registers
   logic [pfcg_pkg::FORMAT_W-1:0]   source_format_ff;
   logic [pfcg_pkg::CHANNELS_W-1:0] out_channels_ff;
   logic                            apply_volume_ff;
   logic [SW-1:0]                   volume_gain_ff;

   // input stage
   logic          in_valid_ff, in_valid_in;
   logic [SW-1:0] first_ff;
   logic [SW-1:0] second_ff;
   logic          last_ff;

   // result stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] out_left_ff, out_left_in;
   logic signed [SW-1:0] out_right_ff, out_right_in;
   logic                 out_last_ff;

   logic req_take;
   logic advance;

   logic          src_stereo, src_wide, mono_out;
   logic [SW-1:0] conv_a, conv_b, chan_b;
   logic [SW:0]   mix_sum, mix_adj;
   logic [SW-1:0] pre_left, pre_right;
   logic signed [SW-1:0] gained_left, gained_right;

   // handshake: advance the input stage when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // format conversion and channel mapping
   always_comb begin
      src_stereo = source_format_ff[0];
      src_wide   = source_format_ff[1];
      mono_out   = (out_channels_ff == pfcg_pkg::CHANNELS_MONO);
      conv_a = pfcg_pkg::to_s16(first_ff, src_wide);
      conv_b = pfcg_pkg::to_s16(second_ff, src_wide);
      chan_b = src_stereo ? conv_b : conv_a;
      // average with truncation toward zero: add one to odd negative sums
      mix_sum = {conv_a[SW-1], conv_a} + {conv_b[SW-1], conv_b};
      mix_adj = mix_sum + {{SW{1'b0}}, mix_sum[SW] & mix_sum[0]};
      if (mono_out) begin
         pre_left  = src_stereo ? mix_adj[SW:1] : conv_a;
         pre_right = '0;
      end else begin
         pre_left  = conv_a;
         pre_right = chan_b;
      end
   end

   pfcg_gain u_gain_left (
      .sample (signed'(pre_left)),
      .gain   (signed'(volume_gain_ff)),
      .scaled (gained_left)
   );

   pfcg_gain u_gain_right (
      .sample (signed'(pre_right)),
      .gain   (signed'(volume_gain_ff)),
      .scaled (gained_right)
   );

   always_comb begin
      if (apply_volume_ff) begin
         out_left_in  = gained_left;
         out_right_in = mono_out ? '0 : gained_right;
      end else begin
         out_left_in  = signed'(pre_left);
         out_right_in = signed'(pre_right);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= pfcg_pkg::SOURCE_FORMAT_RESET;
         out_channels_ff  <= pfcg_pkg::OUT_CHANNELS_RESET;
         apply_volume_ff  <= pfcg_pkg::APPLY_VOLUME_RESET;
         volume_gain_ff   <= pfcg_pkg::VOLUME_GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (pfcg_pkg::csr_index_type'(csr_index))
            pfcg_pkg::CSR_SOURCE_FORMAT: begin
               source_format_ff <= csr_wr_data[pfcg_pkg::FORMAT_W-1:0];
            end
            pfcg_pkg::CSR_OUT_CHANNELS: begin
               out_channels_ff <= csr_wr_data[pfcg_pkg::CHANNELS_W-1:0];
            end
            pfcg_pkg::CSR_APPLY_VOLUME: begin
               apply_volume_ff <= csr_wr_data[0];
            end
            pfcg_pkg::CSR_VOLUME_GAIN: begin
               volume_gain_ff <= csr_wr_data[SW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold the input frame until it moves on, load results on advance
   always_ff @(posedge clock) begin
      if (req_take) begin
         first_ff  <= req.first_sample;
         second_ff <= req.second_sample;
         last_ff   <= req.last_frame;
      end
      if (advance) begin
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_left  = out_left_ff;
   assign rsp.out_right = out_right_ff;
   assign rsp.out_last  = out_last_ff;

endmodule

[tb/pcm_frame_converter_with_gain_core_tb.sv]
`timescale 1ns / 1ps

module pcm_frame_converter_with_gain_core_tb;

   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 10;      // two-stage pipeline plus margin
   localparam int STALL_LIMIT = 4000;     // cycles without any beat
   localparam int RANDOM_PER_PHASE = 367;
   localparam int DIRECTED_COUNT = 24;
   localparam int SW = pfcg_pkg::SAMPLE_W;

   typedef struct packed {
      logic [SW-1:0] first_sample;
      logic [SW-1:0] second_sample;
      logic          last_frame;
   } pcm_in_type;

   typedef struct packed {
      logic signed [SW-1:0] out_left;
      logic signed [SW-1:0] out_right;
      logic                 out_last;
   } pcm_out_type;

   // One directed row: the register setting it runs under, the source frame,
   // and an optional hand-computed result.
   typedef struct packed {
      logic [pfcg_pkg::FORMAT_W-1:0]   fmt;
      logic [pfcg_pkg::CHANNELS_W-1:0] chans;
      logic                            vol_on;
      logic [SW-1:0]                   gain;
      pcm_in_type                      frame;
      logic                            typed;
      pcm_out_type                     result;
   } vector_type;

   // Rows with typed = 0 are checked against the converter model instead.
   localparam vector_type DIRECTED [DIRECTED_COUNT] = '{
      // reset setting: 16-bit mono in, duplicated to stereo out, unity gain
      '{2'd2, 2'd2, 1'b1, 16'h1000, '{16'h8000, 16'h7FFF, 1'b1}, 1'b1,
        '{16'h8000, 16'h8000, 1'b1}},
      '{2'd2, 2'd2, 1'b1, 16'h1000, '{16'h7FFF, 16'h8000, 1'b0}, 1'b1,
        '{16'h7FFF, 16'h7FFF, 1'b0}},
      '{2'd2, 2'd2, 1'b1, 16'h1000, '{16'h1234, 16'hEDCB, 1'b0}, 1'b0,
        '{16'h0000, 16'h0000, 1'b0}},
      // 8-bit mono, upper byte ignored, duplicated to both channels
      '{2'd0, 2'd2, 1'b0, 16'h1000, '{16'hFF00, 16'h1234, 1'b0}, 1'b1,
        '{16'h8000, 16'h8000, 1'b0}},
      '{2'd0, 2'd2, 1'b0, 16'h1000, '{16'h00FF, 16'hFFFF, 1'b1}, 1'b1,
        '{16'h7F00, 16'h7F00, 1'b1}},
      '{2'd1, 2'd2, 1'b0, 16'h1000, '{16'hAB80, 16'h5500, 1'b0}, 1'b1,
        '{16'h0000, 16'h8000, 1'b0}},
      // stereo to mono average, right forced to zero
      '{2'd1, 2'd1, 1'b0, 16'h1000, '{16'h00FF, 16'h0000, 1'b0}, 1'b1,
        '{16'hFF80, 16'h0000, 1'b0}},
      // -1 / 2 truncates toward zero
      '{2'd3, 2'd1, 1'b0, 16'h1000, '{16'hFFFF, 16'h0000, 1'b1}, 1'b1,
        '{16'h0000, 16'h0000, 1'b1}},
      '{2'd3, 2'd1, 1'b0, 16'h1000, '{16'h8000, 16'h8000, 1'b0}, 1'b1,
        '{16'h8000, 16'h0000, 1'b0}},
      // channel counts 0 and 3 fall back to stereo
      '{2'd3, 2'd0, 1'b0, 16'h1000, '{16'h1234, 16'hFEDC, 1'b0}, 1'b1,
        '{16'h1234, 16'hFEDC, 1'b0}},
      '{2'd3, 2'd3, 1'b0, 16'h1000, '{16'h8001, 16'h7FFE, 1'b1}, 1'b1,
        '{16'h8001, 16'h7FFE, 1'b1}},
      '{2'd2, 2'd1, 1'b0, 16'h1000, '{16'h8001, 16'h7777, 1'b0}, 1'b1,
        '{16'h8001, 16'h0000, 1'b0}},
      // zero gain mutes
      '{2'd3, 2'd2, 1'b1, 16'h0000, '{16'h7FFF, 16'h8000, 1'b0}, 1'b1,
        '{16'h0000, 16'h0000, 1'b0}},
      '{2'd3, 2'd2, 1'b1, 16'h1000, '{16'h8000, 16'h7FFF, 1'b1}, 1'b1,
        '{16'h8000, 16'h7FFF, 1'b1}},
      // gain extremes saturate both ways
      '{2'd3, 2'd2, 1'b1, 16'h7FFF, '{16'h7FFF, 16'h8000, 1'b0}, 1'b1,
        '{16'h7FFF, 16'h8000, 1'b0}},
      '{2'd3, 2'd2, 1'b1, 16'h8000, '{16'h7FFF, 16'h8000, 1'b0}, 1'b1,
        '{16'h8000, 16'h7FFF, 1'b0}},
      '{2'd3, 2'd2, 1'b1, 16'h8000, '{16'h0001, 16'hFFFF, 1'b0}, 1'b1,
        '{16'hFFF8, 16'h0008, 1'b0}},
      // tiny gain: products truncate toward zero from both sides
      '{2'd3, 2'd2, 1'b1, 16'h0001, '{16'h0FFF, 16'hF001, 1'b1}, 1'b1,
        '{16'h0000, 16'h0000, 1'b1}},
      '{2'd3, 2'd1, 1'b1, 16'h2000, '{16'h4000, 16'h4000, 1'b0}, 1'b1,
        '{16'h7FFF, 16'h0000, 1'b0}},
      '{2'd1, 2'd1, 1'b1, 16'h1800, '{16'h3C91, 16'hA27F, 1'b0}, 1'b0,
        '{16'h0000, 16'h0000, 1'b0}},
      // -1.0 gain on the most negative 8-bit value clips high
      '{2'd0, 2'd1, 1'b1, 16'hF000, '{16'hFF00, 16'hABCD, 1'b1}, 1'b1,
        '{16'h7FFF, 16'h0000, 1'b1}},
      '{2'd2, 2'd2, 1'b1, 16'h0800, '{16'h1357, 16'hFFFF, 1'b0}, 1'b0,
        '{16'h0000, 16'h0000, 1'b0}},
      // gain disabled ignores a zero gain
      '{2'd3, 2'd2, 1'b0, 16'h0000, '{16'h5555, 16'hAAAA, 1'b1}, 1'b0,
        '{16'h0000, 16'h0000, 1'b0}},
      '{2'd2, 2'd3, 1'b1, 16'hC000, '{16'h9ABC, 16'h1111, 1'b0}, 1'b0,
        '{16'h0000, 16'h0000, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Source side of req, held in plain variables so every input is known at time 0.
   logic        src_valid = 1'b0;
   pcm_in_type  src_frame = '0;
   logic        src_typed = 1'b0;
   pcm_out_type src_expect = '0;
   logic        sink_ready = 1'b0;

   logic                             csr_wr_en = 1'b0;
   logic [pfcg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pfcg_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Register mirror: what the block holds right now.
   logic [pfcg_pkg::FORMAT_W-1:0]   cfg_format = pfcg_pkg::SOURCE_FORMAT_RESET;
   logic [pfcg_pkg::CHANNELS_W-1:0] cfg_channels = pfcg_pkg::OUT_CHANNELS_RESET;
   logic                            cfg_volume_on = pfcg_pkg::APPLY_VOLUME_RESET;
   logic [SW-1:0]                   cfg_gain = pfcg_pkg::VOLUME_GAIN_RESET;

   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   pcm_out_type expected_frames[$];

   pfcg_req_if req_bus ();
   pfcg_rsp_if rsp_bus ();

   assign req_bus.valid = src_valid;
   assign req_bus.first_sample = src_frame.first_sample;
   assign req_bus.second_sample = src_frame.second_sample;
   assign req_bus.last_frame = src_frame.last_frame;
   assign rsp_bus.ready = sink_ready;

   pcm_frame_converter_with_gain_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Multiply by the Q4.12 gain, truncate toward zero, clamp to 16 bits.
   function automatic int apply_gain(input int s, input int g);
      int p;
      p = (s * g) / (1 << pfcg_pkg::Q_FRAC_BITS);
      if (p < int'(pfcg_pkg::S16_MIN)) begin
         p = int'(pfcg_pkg::S16_MIN);
      end
      if (p > int'(pfcg_pkg::S16_MAX)) begin
         p = int'(pfcg_pkg::S16_MAX);
      end
      return p;
   endfunction

   // Expected output frame for one source frame under the given setting.
   function automatic pcm_out_type convert_frame(
         input pcm_in_type f,
         input logic [pfcg_pkg::FORMAT_W-1:0] fmt,
         input logic [pfcg_pkg::CHANNELS_W-1:0] chans,
         input logic vol_on,
         input logic [SW-1:0] gain);
      int a;
      int b;
      int l;
      int r;
      logic mono;
      pcm_out_type res;
      // bit 1 of the format selects 16-bit samples, bit 0 a stereo source
      if (fmt[1]) begin
         a = int'($signed(f.first_sample));
         b = int'($signed(f.second_sample));
      end else begin
         a = (int'(f.first_sample[7:0]) - 128) * 256;
         b = (int'(f.second_sample[7:0]) - 128) * 256;
      end
      if (!fmt[0]) begin
         b = a;
      end
      mono = (chans == pfcg_pkg::CHANNELS_MONO);
      if (mono) begin
         l = fmt[0] ? (a + b) / 2 : a;
         r = 0;
      end else begin
         l = a;
         r = b;
      end
      if (vol_on) begin
         l = apply_gain(l, int'($signed(gain)));
         if (!mono) begin
            r = apply_gain(r, int'($signed(gain)));
         end
      end
      res.out_left = l[SW-1:0];
      res.out_right = r[SW-1:0];
      res.out_last = f.last_frame;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Record an expectation for every accepted req beat. Typed rows bring their own.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (src_typed) begin
            expected_frames.push_back(src_expect);
         end else begin
            expected_frames.push_back(convert_frame(src_frame, cfg_format, cfg_channels,
                                                    cfg_volume_on, cfg_gain));
         end
      end
   end

   // Check each accepted rsp beat against the oldest expectation, then pick
   // the next ready value from the current stall rate.
   always @(posedge clock) begin
      pcm_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_frames.size() == 0) begin
            flag_mismatch("unexpected rsp beat, out_left", int'(rsp_bus.out_left), 0);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_bus.out_left !== want.out_left) begin
               flag_mismatch("out_left", int'(rsp_bus.out_left), int'(want.out_left));
            end
            if (rsp_bus.out_right !== want.out_right) begin
               flag_mismatch("out_right", int'(rsp_bus.out_right), int'(want.out_right));
            end
            if (rsp_bus.out_last !== want.out_last) begin
               flag_mismatch("out_last", int'(rsp_bus.out_last), int'(want.out_last));
            end
         end
      end
      sink_ready <= !reset && ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (!reset && ((req_bus.valid && req_bus.ready) ||
                     (rsp_bus.valid && rsp_bus.ready))) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("pcm_frame_converter_with_gain_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drop valid and hold until every expected frame has come back.
   task automatic wait_for_results();
      src_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_frames.size() != 0);
   endtask

   // Offer one req beat, idling first at the current sender rate; return at
   // the edge that accepts it.
   task automatic send_frame(input pcm_in_type f, input logic typed,
                             input pcm_out_type result);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         src_valid <= 1'b0;
         @(posedge clock);
      end
      src_valid <= 1'b1;
      src_frame <= f;
      src_typed <= typed;
      src_expect <= result;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   task automatic csr_write(input pfcg_pkg::csr_index_type idx,
                            input logic [pfcg_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Apply a new register setting once the pipeline is empty. Narrow registers
   // get random upper data bits, which the block must drop.
   task automatic program_csr(input logic [pfcg_pkg::FORMAT_W-1:0] fmt,
                              input logic [pfcg_pkg::CHANNELS_W-1:0] chans,
                              input logic vol_on,
                              input logic [SW-1:0] gain);
      if (fmt == cfg_format && chans == cfg_channels && vol_on == cfg_volume_on &&
          gain == cfg_gain) begin
         return;
      end
      wait_for_results();
      csr_write(pfcg_pkg::CSR_SOURCE_FORMAT, {14'($urandom), fmt});
      csr_write(pfcg_pkg::CSR_OUT_CHANNELS, {14'($urandom), chans});
      csr_write(pfcg_pkg::CSR_APPLY_VOLUME, {15'($urandom), vol_on});
      csr_write(pfcg_pkg::CSR_VOLUME_GAIN, gain);
      csr_wr_en <= 1'b0;
      cfg_format = fmt;
      cfg_channels = chans;
      cfg_volume_on = vol_on;
      cfg_gain = gain;
   endtask

   // Lean random gains toward mute, unity and the extremes.
   task automatic shuffle_setting();
      logic [SW-1:0] gain;
      case ($urandom_range(0, 7))
         0: gain = 16'h0000;
         1: gain = 16'h1000;
         2: gain = 16'h7FFF;
         3: gain = 16'h8000;
         4: gain = 16'hF000;
         default: gain = 16'($urandom);
      endcase
      program_csr(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), gain);
   endtask

   function automatic logic [SW-1:0] pick_sample();
      logic [SW-1:0] s;
      case ($urandom_range(0, 9))
         0: s = 16'h8000;
         1: s = 16'h7FFF;
         2: s = 16'h0000;
         3: s = 16'hFFFF;
         4: s = {8'($urandom), 8'h00};
         5: s = {8'($urandom), 8'hFF};
         default: s = 16'($urandom);
      endcase
      return s;
   endfunction

   // One phase of random frames: new settings now and then, and an
   // occasional full drain before going on.
   task automatic run_random(input int count);
      pcm_in_type f;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) begin
            shuffle_setting();
         end else if ($urandom_range(0, 49) == 0) begin
            wait_for_results();
         end
         f.first_sample = pick_sample();
         f.second_sample = pick_sample();
         f.last_frame = 1'($urandom_range(0, 1));
         send_frame(f, 1'b0, '0);
      end
   endtask

   initial begin
      vector_type v;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: the first ones run on the reset setting with no write.
      src_idle_pct = 23;
      sink_idle_pct = 68;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         v = DIRECTED[i];
         program_csr(v.fmt, v.chans, v.vol_on, v.gain);
         send_frame(v.frame, v.typed, v.result);
      end
      // Hold the sender until everything is back before the random part.
      wait_for_results();

      shuffle_setting();
      run_random(RANDOM_PER_PHASE);

      src_idle_pct = 68;
      sink_idle_pct = 23;
      shuffle_setting();
      run_random(RANDOM_PER_PHASE);

      // Full rate on both sides.
      src_idle_pct = 0;
      sink_idle_pct = 0;
      shuffle_setting();
      run_random(RANDOM_PER_PHASE);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pcm_frame_converter_with_gain_core regression: pass");
      end else begin
         $display("pcm_frame_converter_with_gain_core regression: fail");
      end
      $finish;
   end

endmodule
